@@ design/mips_r3000_integer_core_unit_defines.svh @@
// Assertion macros used by the core's controller.
// No dependencies.
`ifndef MIPS_R3000_INTEGER_CORE_UNIT_DEFINES_SVH
`define MIPS_R3000_INTEGER_CORE_UNIT_DEFINES_SVH
// assert an implication on the rising clock, disabled in reset
`define MRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert a next-cycle implication
`define MRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/mrc_pkg.sv @@
// Package for the R3000A core: opcodes, state codes, command/status structs.
// No dependencies.
package mrc_pkg;
    localparam logic [31:0] RESET_VECTOR = 32'hbfc0_0000;
    localparam logic [31:0] VEC_BEV0     = 32'h8000_0080;
    localparam logic [31:0] VEC_BEV1     = 32'hbfc0_0180;
    localparam logic [31:0] SEG_MASK     = 32'hf000_0000;
    localparam logic [25:0] TARGET_MASK  = 26'h3ff_ffff;
    localparam logic [4:0]  SHIFT_MASK   = 5'h1f;
    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNIMP = 2'd1;
    localparam logic [1:0] ST_JADDR = 2'd2;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SWR     = 6'h2e;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_SRAV = 6'h07;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_SYSC = 6'h0c;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MTHI = 6'h11;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MTLO = 6'h13;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_MULTU= 6'h19;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_DIVU = 6'h1b;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;
    localparam logic [5:0] FN_RFE  = 6'h10;

    localparam logic [4:0] RS_MFC0 = 5'd0;
    localparam logic [4:0] RS_MTC0 = 5'd4;

    localparam logic [3:0] CP_SR    = 4'd12;
    localparam logic [3:0] CP_CAUSE = 4'd13;
    localparam logic [3:0] CP_EPC   = 4'd14;
    localparam logic [4:0] EXC_SYS  = 5'd8;

    localparam logic [2:0] LK_LB  = 3'd0;
    localparam logic [2:0] LK_LH  = 3'd1;
    localparam logic [2:0] LK_LWL = 3'd2;
    localparam logic [2:0] LK_LBU = 3'd4;
    localparam logic [2:0] LK_LHU = 3'd5;
    localparam logic [2:0] LK_LWR = 3'd6;

    // controller state codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    typedef struct packed {
        logic       exec;   // latch and execute an instruction beat
        logic       load;   // complete a load-data beat
        logic       mul_hi; // second multiply partial step
        logic       div_step;
        logic       div_fin;
    } cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_done;
    } stat_t;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic [1:0]  bus_request;
        logic [31:0] bus_address;
        logic [31:0] bus_write_data;
        logic [3:0]  byte_enables;
        logic [1:0]  status;
    } result_t;
endpackage

@@ design/mrc_ctrl.sv @@
// Controller FSM for the R3000A core: sequences execute, load, multiply, divide, output.
// Depends on mrc_pkg and the defines header.
`include "mips_r3000_integer_core_unit_defines.svh"
module mrc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_op,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  mrc_pkg::stat_t  stat,
    output mrc_pkg::cmd_t   cmd
);
    logic [2:0] state_reg, state_next;

    assign in_ready  = (state_reg == mrc_pkg::S_IDLE);
    assign out_valid = (state_reg == mrc_pkg::S_OUT);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            mrc_pkg::S_IDLE: begin
                if (in_valid) begin
                    cmd.exec = !in_op;
                    cmd.load = in_op;
                    state_next = in_op ? mrc_pkg::S_OUT : mrc_pkg::S_EXEC;
                end
            end
            mrc_pkg::S_EXEC: begin
                if (stat.is_mul) begin
                    state_next = mrc_pkg::S_MUL2;
                end else if (stat.is_div) begin
                    state_next = mrc_pkg::S_DIV;
                end else begin
                    state_next = mrc_pkg::S_OUT;
                end
            end
            mrc_pkg::S_MUL2: begin
                cmd.mul_hi = 1'b1;
                state_next = mrc_pkg::S_OUT;
            end
            mrc_pkg::S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_fin = 1'b1;
                    state_next = mrc_pkg::S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            mrc_pkg::S_OUT: begin
                if (out_ready) state_next = mrc_pkg::S_IDLE;
            end
            default: state_next = mrc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= mrc_pkg::S_IDLE;
        else          state_reg <= state_next;
    end

    `MRC_ASSERT_IMPL(a_rdy_nout, aclk, aresetn, in_ready, !out_valid)
    `MRC_ASSERT_NEXT(a_exec_leaves, aclk, aresetn, cmd.exec, !in_ready)
    `MRC_ASSERT_NEXT(a_load_out, aclk, aresetn, cmd.load, out_valid)
endmodule

@@ design/mrc_dpath.sv @@
// Datapath of the R3000A core: register file, hi/lo, pc, COP0, ALU, mul, divider.
// Depends on mrc_pkg.
module mrc_dpath (
    input  logic             aclk,
    input  logic             aresetn,
    input  mrc_pkg::cmd_t    cmd,
    output mrc_pkg::stat_t   stat,
    input  logic [31:0]      in_instr,
    input  logic [31:0]      in_ldata,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_start,
    output mrc_pkg::result_t res
);
    logic [31:0] gpr [32];
    logic [31:0] cp_reg [16];
    logic [31:0] hi_reg, lo_reg, pc_reg, npc_reg;
    logic [11:0] pend_reg;
    logic [31:0] ir_reg;
    logic [31:0] vs_reg, vt_reg;
    logic [1:0]  bus_req_reg, st_reg;
    logic [31:0] baddr_reg, wdata_reg;
    logic [3:0]  be_reg;
    // multiply: two 32x16 partial products
    logic [63:0] pp_reg;
    logic        msign_reg;
    // divider
    logic [5:0]  dcnt_reg;
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic        dqneg_reg, drneg_reg, dspec_reg;
    logic [31:0] dspec_lo_reg, dspec_hi_reg;

    // decoded fields of the latched instruction
    logic [5:0] opc, fn;
    logic [4:0] rs, rt, rd, sa;
    logic [31:0] simm, imm, ea;
    assign opc  = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sa   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign imm  = {16'h0, ir_reg[15:0]};
    assign simm = {{16{ir_reg[15]}}, ir_reg[15:0]};
    assign ea   = vs_reg + simm;

    assign stat.is_mul   = (opc == mrc_pkg::OP_SPECIAL) &&
                           (fn == mrc_pkg::FN_MULT || fn == mrc_pkg::FN_MULTU);
    assign stat.is_div   = (opc == mrc_pkg::OP_SPECIAL) &&
                           (fn == mrc_pkg::FN_DIV || fn == mrc_pkg::FN_DIVU);
    assign stat.div_done = dspec_reg || (dcnt_reg == 6'd32);

    // execute-stage results
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic [1:0]  st_c, req_c;
    logic [31:0] wdata_c;
    logic [3:0]  be_c;
    logic        npc_ld;
    logic [31:0] npc_val;
    logic        hi_wr, lo_wr;
    logic        sys_c, rfe_c, mtc0_c, ld_c;
    logic [31:0] pc1, npc1, btgt;
    logic        neg;
    logic [1:0]  a;
    logic [4:0]  ls;

    always_comb begin
        pc1     = npc_reg;
        npc1    = npc_reg + 32'd4;
        btgt    = pc1 + {simm[29:0], 2'b00};
        neg     = vs_reg[31];
        a       = ea[1:0];
        wr_en   = 1'b0;
        wr_idx  = rd;
        wr_val  = '0;
        st_c    = mrc_pkg::ST_OK;
        req_c   = mrc_pkg::REQ_NONE;
        wdata_c = '0;
        be_c    = '0;
        npc_ld  = 1'b0;
        npc_val = '0;
        hi_wr   = 1'b0;
        lo_wr   = 1'b0;
        sys_c   = 1'b0;
        rfe_c   = 1'b0;
        mtc0_c  = 1'b0;
        ld_c    = 1'b0;
        ls      = vs_reg[4:0] & mrc_pkg::SHIFT_MASK;
        unique case (opc)
            mrc_pkg::OP_SPECIAL: begin
                wr_en = 1'b1;
                unique case (fn)
                    mrc_pkg::FN_SLL:  wr_val = vt_reg << sa;
                    mrc_pkg::FN_SRL:  wr_val = vt_reg >> sa;
                    mrc_pkg::FN_SRA:  wr_val = 32'($signed(vt_reg) >>> sa);
                    mrc_pkg::FN_SLLV: wr_val = vt_reg << ls;
                    mrc_pkg::FN_SRLV: wr_val = vt_reg >> ls;
                    mrc_pkg::FN_SRAV: wr_val = 32'($signed(vt_reg) >>> ls);
                    mrc_pkg::FN_JR, mrc_pkg::FN_JALR: begin
                        wr_en = 1'b0;
                        if (vs_reg[1:0] != 2'b00) begin
                            st_c = mrc_pkg::ST_JADDR;
                        end else begin
                            wr_en   = (fn == mrc_pkg::FN_JALR);
                            wr_val  = npc1;
                            npc_ld  = 1'b1;
                            npc_val = vs_reg;
                        end
                    end
                    mrc_pkg::FN_SYSC: begin
                        wr_en = 1'b0;
                        sys_c = 1'b1;
                    end
                    mrc_pkg::FN_MFHI: wr_val = hi_reg;
                    mrc_pkg::FN_MTHI: begin wr_en = 1'b0; hi_wr = 1'b1; end
                    mrc_pkg::FN_MFLO: wr_val = lo_reg;
                    mrc_pkg::FN_MTLO: begin wr_en = 1'b0; lo_wr = 1'b1; end
                    mrc_pkg::FN_MULT, mrc_pkg::FN_MULTU,
                    mrc_pkg::FN_DIV, mrc_pkg::FN_DIVU: wr_en = 1'b0;
                    mrc_pkg::FN_ADD, mrc_pkg::FN_ADDU: wr_val = vs_reg + vt_reg;
                    mrc_pkg::FN_SUB, mrc_pkg::FN_SUBU: wr_val = vs_reg - vt_reg;
                    mrc_pkg::FN_AND:  wr_val = vs_reg & vt_reg;
                    mrc_pkg::FN_OR:   wr_val = vs_reg | vt_reg;
                    mrc_pkg::FN_XOR:  wr_val = vs_reg ^ vt_reg;
                    mrc_pkg::FN_NOR:  wr_val = ~(vs_reg | vt_reg);
                    mrc_pkg::FN_SLT:  wr_val = {31'h0, $signed(vs_reg) < $signed(vt_reg)};
                    mrc_pkg::FN_SLTU: wr_val = {31'h0, vs_reg < vt_reg};
                    default: begin wr_en = 1'b0; st_c = mrc_pkg::ST_UNIMP; end
                endcase
            end
            mrc_pkg::OP_REGIMM: begin
                if (rt[3:1] == 3'b000) begin
                    wr_en  = rt[4];
                    wr_idx = 5'd31;
                    wr_val = npc1;
                    npc_ld = rt[0] ? !neg : neg;
                    npc_val = btgt;
                end else begin
                    st_c = mrc_pkg::ST_UNIMP;
                end
            end
            mrc_pkg::OP_J, mrc_pkg::OP_JAL: begin
                wr_en   = (opc == mrc_pkg::OP_JAL);
                wr_idx  = 5'd31;
                wr_val  = npc1;
                npc_ld  = 1'b1;
                npc_val = (pc1 & mrc_pkg::SEG_MASK) | {4'h0, ir_reg[25:0] & mrc_pkg::TARGET_MASK, 2'b00};
            end
            mrc_pkg::OP_BEQ:  begin npc_ld = (vs_reg == vt_reg); npc_val = btgt; end
            mrc_pkg::OP_BNE:  begin npc_ld = (vs_reg != vt_reg); npc_val = btgt; end
            mrc_pkg::OP_BLEZ: begin npc_ld = (vs_reg == 0) || neg; npc_val = btgt; end
            mrc_pkg::OP_BGTZ: begin npc_ld = (vs_reg != 0) && !neg; npc_val = btgt; end
            mrc_pkg::OP_ADDI, mrc_pkg::OP_ADDIU: begin
                wr_en = 1'b1; wr_idx = rt; wr_val = vs_reg + simm;
            end
            mrc_pkg::OP_SLTI: begin
                wr_en = 1'b1; wr_idx = rt;
                wr_val = {31'h0, $signed(vs_reg) < $signed(simm)};
            end
            mrc_pkg::OP_SLTIU: begin
                wr_en = 1'b1; wr_idx = rt; wr_val = {31'h0, vs_reg < simm};
            end
            mrc_pkg::OP_ANDI: begin wr_en = 1'b1; wr_idx = rt; wr_val = vs_reg & imm; end
            mrc_pkg::OP_ORI:  begin wr_en = 1'b1; wr_idx = rt; wr_val = vs_reg | imm; end
            mrc_pkg::OP_XORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = vs_reg ^ imm; end
            mrc_pkg::OP_LUI:  begin
                wr_en = 1'b1; wr_idx = rt; wr_val = {ir_reg[15:0], 16'h0};
            end
            mrc_pkg::OP_COP0: begin
                wr_idx = rt;
                if (ir_reg[25]) begin
                    if (fn == mrc_pkg::FN_RFE) rfe_c = 1'b1;
                    else st_c = mrc_pkg::ST_UNIMP;
                end else if (rs == mrc_pkg::RS_MFC0) begin
                    wr_en  = 1'b1;
                    wr_val = rd[4] ? 32'h0 : cp_reg[rd[3:0]];
                end else if (rs == mrc_pkg::RS_MTC0) begin
                    mtc0_c = !rd[4];
                end else begin
                    st_c = mrc_pkg::ST_UNIMP;
                end
            end
            mrc_pkg::OP_SB: begin
                req_c = mrc_pkg::REQ_WRITE;
                wdata_c = {24'h0, vt_reg[7:0]} << {a, 3'b000};
                be_c = 4'b0001 << a;
            end
            mrc_pkg::OP_SH: begin
                req_c = mrc_pkg::REQ_WRITE;
                wdata_c = {16'h0, vt_reg[15:0]} << {a[1], 4'h0};
                be_c = 4'b0011 << {a[1], 1'b0};
            end
            mrc_pkg::OP_SWL: begin
                req_c = mrc_pkg::REQ_WRITE;
                wdata_c = vt_reg >> (5'd24 - {a, 3'b000});
                be_c = 4'((5'd2 << a) - 5'd1);
            end
            mrc_pkg::OP_SW: begin
                req_c = mrc_pkg::REQ_WRITE;
                wdata_c = vt_reg;
                be_c = 4'hf;
            end
            mrc_pkg::OP_SWR: begin
                req_c = mrc_pkg::REQ_WRITE;
                wdata_c = vt_reg << {a, 3'b000};
                be_c = 4'hf << a;
            end
            default: begin
                if (opc[5:3] == 3'b100 && opc[2:0] != 3'b111) begin
                    req_c = mrc_pkg::REQ_READ;
                    ld_c  = 1'b1;
                end else begin
                    st_c = mrc_pkg::ST_UNIMP;
                end
            end
        endcase
    end

    // load completion
    logic [2:0]  lk;
    logic [4:0]  lreg;
    logic [1:0]  la;
    logic [31:0] lold, lval, lsh, lsh2;
    always_comb begin
        lk   = pend_reg[9:7];
        lreg = pend_reg[6:2];
        la   = pend_reg[1:0];
        lold = gpr[lreg];
        lsh  = in_ldata >> {la, 3'b000};
        lsh2 = in_ldata >> {la[1], 4'h0};
        case (lk)
            mrc_pkg::LK_LB:  lval = {{24{lsh[7]}}, lsh[7:0]};
            mrc_pkg::LK_LH:  lval = {{16{lsh2[15]}}, lsh2[15:0]};
            mrc_pkg::LK_LWL: lval = (lold & (32'h00ff_ffff >> {la, 3'b000})) |
                                    (in_ldata << (5'd24 - {la, 3'b000}));
            mrc_pkg::LK_LBU: lval = {24'h0, lsh[7:0]};
            mrc_pkg::LK_LHU: lval = {16'h0, lsh2[15:0]};
            mrc_pkg::LK_LWR: lval = (lold & ~(mrc_pkg::ALL_ONES >> {la, 3'b000})) | lsh;
            default:         lval = in_ldata;
        endcase
    end

    // multiplier operands: |vs| x |vt| low and high halves of vt
    logic [31:0] mabs_s, mabs_t;
    logic        msgn;
    logic [47:0] mprod, mprod_lo;
    logic [63:0] mfull;
    always_comb begin
        msgn     = (fn == mrc_pkg::FN_MULT) && (vs_reg[31] ^ vt_reg[31]);
        mabs_s   = (fn == mrc_pkg::FN_MULT && vs_reg[31]) ? -vs_reg : vs_reg;
        mabs_t   = (fn == mrc_pkg::FN_MULT && vt_reg[31]) ? -vt_reg : vt_reg;
        mprod_lo = mabs_s * mabs_t[15:0];
        mprod    = mabs_s * mabs_t[31:16];
        mfull    = pp_reg + {mprod, 16'h0};
    end

    // divider restoring step
    logic [32:0] dtrial;
    logic [31:0] drem_sh;
    always_comb begin
        drem_sh = {dr_reg[30:0], dq_reg[31]};
        dtrial  = {dr_reg, dq_reg[31]} - {1'b0, dd_reg};
    end

    // divide setup values
    logic        dsign;
    logic [31:0] da, db;
    assign dsign = (fn == mrc_pkg::FN_DIV);
    assign da = (dsign && vs_reg[31]) ? -vs_reg : vs_reg;
    assign db = (dsign && vt_reg[31]) ? -vt_reg : vt_reg;

    logic [31:0] sr_push;
    assign sr_push = {cp_reg[mrc_pkg::CP_SR][31:6], cp_reg[mrc_pkg::CP_SR][3:0], 2'b00};

    // execute strobe: cmd.exec registered, high in the cycle after the instruction is latched
    logic exec_q;
    always_ff @(posedge aclk) begin
        if (!aresetn) exec_q <= 1'b0;
        else          exec_q <= cmd.exec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) gpr[i] <= '0;
            for (int i = 0; i < 16; i++) cp_reg[i] <= '0;
            hi_reg <= '0; lo_reg <= '0;
            pc_reg <= mrc_pkg::RESET_VECTOR;
            npc_reg <= mrc_pkg::RESET_VECTOR + 32'd4;
            pend_reg <= '0;
            ir_reg <= '0;
            bus_req_reg <= '0; st_reg <= '0;
            dcnt_reg <= '0; dspec_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                pc_reg  <= cfg_start;
                npc_reg <= cfg_start + 32'd4;
            end
            if (cmd.exec) begin
                ir_reg <= in_instr;
                vs_reg <= gpr[in_instr[25:21]];
                vt_reg <= gpr[in_instr[20:16]];
            end
            if (cmd.load) begin
                if (pend_reg[11] && lreg != 5'd0) gpr[lreg] <= lval;
                pend_reg    <= '0;
                bus_req_reg <= mrc_pkg::REQ_NONE;
                baddr_reg   <= '0; wdata_reg <= '0; be_reg <= '0;
                st_reg      <= mrc_pkg::ST_OK;
            end
            // execute cycle: controller is in EXEC state when neither cmd is set
            if (exec_q) begin
                pend_reg <= ld_c ? {1'b1, 1'b0, opc[2:0], rt, a} : 12'h0;
                if (wr_en && wr_idx != 5'd0) gpr[wr_idx] <= wr_val;
                if (hi_wr) hi_reg <= vs_reg;
                if (lo_wr) lo_reg <= vs_reg;
                if (mtc0_c) cp_reg[rd[3:0]] <= vt_reg;
                if (rfe_c) cp_reg[mrc_pkg::CP_SR][3:0] <= cp_reg[mrc_pkg::CP_SR][5:2];
                if (sys_c) begin
                    cp_reg[mrc_pkg::CP_EPC] <= pc_reg;
                    cp_reg[mrc_pkg::CP_SR]  <= sr_push;
                    cp_reg[mrc_pkg::CP_CAUSE][6:2] <= mrc_pkg::EXC_SYS;
                    pc_reg  <= sr_push[22] ? mrc_pkg::VEC_BEV1 : mrc_pkg::VEC_BEV0;
                    npc_reg <= (sr_push[22] ? mrc_pkg::VEC_BEV1 : mrc_pkg::VEC_BEV0) + 32'd4;
                end else begin
                    pc_reg  <= pc1;
                    npc_reg <= npc_ld ? npc_val : npc1;
                end
                bus_req_reg <= req_c;
                baddr_reg   <= (req_c != mrc_pkg::REQ_NONE) ? {ea[31:2], 2'b00} : 32'h0;
                wdata_reg   <= wdata_c;
                be_reg      <= be_c;
                st_reg      <= st_c;
                // multiply, first partial product on the low half of vt
                pp_reg    <= {16'h0, mprod_lo};
                msign_reg <= msgn;
                // divide setup
                dcnt_reg  <= '0;
                dq_reg    <= da;
                dr_reg    <= '0;
                dd_reg    <= db;
                dqneg_reg <= dsign && (vs_reg[31] ^ vt_reg[31]);
                drneg_reg <= dsign && vs_reg[31];
                dspec_reg <= stat.is_div &&
                             ((vt_reg == 32'h0) ||
                              (dsign && vs_reg == 32'h8000_0000 && vt_reg == mrc_pkg::ALL_ONES));
                dspec_lo_reg <= (vt_reg == 32'h0) ? mrc_pkg::ALL_ONES : 32'h8000_0000;
                dspec_hi_reg <= (vt_reg == 32'h0) ? vs_reg : 32'h0;
            end
            if (cmd.mul_hi) begin
                lo_reg <= msign_reg ? 32'(-mfull) : mfull[31:0];
                hi_reg <= msign_reg ? 32'((-mfull) >> 32) : mfull[63:32];
            end
            if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (!dtrial[32]) begin
                    dr_reg <= dtrial[31:0];
                    dq_reg <= {dq_reg[30:0], 1'b1};
                end else begin
                    dr_reg <= drem_sh;
                    dq_reg <= {dq_reg[30:0], 1'b0};
                end
            end
            if (cmd.div_fin) begin
                dspec_reg <= 1'b0;
                if (dspec_reg) begin
                    lo_reg <= dspec_lo_reg;
                    hi_reg <= dspec_hi_reg;
                end else begin
                    lo_reg <= dqneg_reg ? -dq_reg : dq_reg;
                    hi_reg <= drneg_reg ? -dr_reg : dr_reg;
                end
            end
        end
    end

    assign res.fetch_address  = pc_reg;
    assign res.bus_request    = bus_req_reg;
    assign res.bus_address    = baddr_reg;
    assign res.bus_write_data = wdata_reg;
    assign res.byte_enables   = be_reg;
    assign res.status         = st_reg;
endmodule

@@ design/mips_r3000_integer_core_unit.sv @@
// MIPS R3000A integer core, one instruction word or load-data beat per input beat,
// one result beat per input beat. Most instructions pass through latch and register
// read, execute and output; MULT/MULTU add a second multiply step (two 32x16 partial
// products); DIV/DIVU run the shared restoring divider (one quotient bit a cycle), with
// no quotient steps for divide by zero or signed overflow. A load-data beat goes straight to output.
// The block holds one item at a time. start_address at APB offset 0 reloads pc.
// Depends on mrc_pkg, mrc_ctrl, mrc_dpath.
module mips_r3000_integer_core_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,  // instruction_word[31:0], load_word[63:32]
    input  logic         s_tuser,  // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,  // fetch_address, bus_request, bus_address,
                                   // bus_write_data, byte_enables, status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    mrc_pkg::cmd_t    cmd;
    mrc_pkg::stat_t   stat;
    mrc_pkg::result_t res;
    logic [31:0]      start_reg;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? start_reg : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn)    start_reg <= mrc_pkg::RESET_VECTOR;
        else if (cfg_we) start_reg <= pwdata;
    end

    mrc_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .stat, .cmd
    );

    mrc_dpath u_dpath (
        .aclk, .aresetn, .cmd, .stat,
        .in_instr (s_tdata[31:0]),
        .in_ldata (s_tdata[63:32]),
        .cfg_we,
        .cfg_start(pwdata),
        .res
    );

    assign m_tdata = {res.status, res.byte_enables, res.bus_write_data,
                      res.bus_address, res.bus_request, res.fetch_address};
endmodule

@@ test/mrc_result_checker.sv @@
// Scoreboard for the R3000A core: watches the APB port and both stream channels,
// predicts one result beat per input beat and compares it field by field.
// Depends on mrc_pkg.
module mrc_result_checker
    import mrc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           mismatch_count,
    output int           results_due
);
    localparam logic [1:0] ADDR_START = 2'd0;

    // architectural copy of the core
    logic [31:0] gpr [32];
    logic [31:0] cp0 [16];
    logic [31:0] hi_q, lo_q, pc_q, npc_q;
    logic        ld_pend;
    logic [2:0]  ld_kind;
    logic [4:0]  ld_reg;
    logic [1:0]  ld_low;

    result_t expected_results[$];

    assign results_due = expected_results.size();

    task automatic write_gpr(input logic [4:0] idx, input logic [31:0] v);
        gpr[idx] = v;
        gpr[0]   = '0;
    endtask

    task automatic complete_load(input logic [31:0] w);
        logic [31:0] prev, v, bsh, hsh;
        prev = gpr[ld_reg];
        bsh  = w >> (8 * ld_low);
        hsh  = w >> (8 * (ld_low & 2'd2));
        case (ld_kind)
            LK_LB:  v = {{24{bsh[7]}}, bsh[7:0]};
            LK_LH:  v = {{16{hsh[15]}}, hsh[15:0]};
            LK_LWL: v = (prev & (32'h00ff_ffff >> (8 * ld_low))) | (w << (24 - 8 * ld_low));
            LK_LBU: v = {24'd0, bsh[7:0]};
            LK_LHU: v = {16'd0, hsh[15:0]};
            LK_LWR: v = (prev & ~(ALL_ONES >> (8 * ld_low))) | (w >> (8 * ld_low));
            default: v = w;
        endcase
        write_gpr(ld_reg, v);
    endtask

    task automatic signed_divide(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q, r;
        if (b == 0) begin
            lo_q = ALL_ONES;
            hi_q = a;
        end else if (a == 32'h8000_0000 && b == ALL_ONES) begin
            lo_q = 32'h8000_0000;
            hi_q = '0;
        end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q  = ma / mb;
            r  = ma % mb;
            lo_q = (a[31] ^ b[31]) ? -q : q;
            hi_q = a[31] ? -r : r;
        end
    endtask

    // execute one input beat and return the result the core should emit
    task automatic execute_beat(input logic op, input logic [31:0] w, input logic [31:0] ldw,
                                output result_t r);
        logic [5:0]  opc, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic [31:0] imm, simm, vs, vt, ea, iaddr, btgt, sr;
        logic [1:0]  a;
        logic [63:0] prod;
        logic        neg, take;
        r = '0;
        if (op) begin
            if (ld_pend)
                complete_load(ldw);
            ld_pend = 1'b0;
        end else begin
            opc = w[31:26]; rs = w[25:21]; rt = w[20:16];
            rd  = w[15:11]; sa = w[10:6];  fn = w[5:0];
            imm  = {16'd0, w[15:0]};
            simm = {{16{w[15]}}, w[15:0]};
            vs = gpr[rs]; vt = gpr[rt];
            ea = vs + simm; a = ea[1:0];
            iaddr = pc_q;
            ld_pend = 1'b0;
            pc_q  = npc_q;
            npc_q = npc_q + 4;
            btgt  = pc_q + (simm << 2);
            case (opc)
                OP_SPECIAL: begin
                    case (fn)
                        FN_SLL:  write_gpr(rd, vt << sa);
                        FN_SRL:  write_gpr(rd, vt >> sa);
                        FN_SRA:  write_gpr(rd, $unsigned($signed(vt) >>> sa));
                        FN_SLLV: write_gpr(rd, vt << vs[4:0]);
                        FN_SRLV: write_gpr(rd, vt >> vs[4:0]);
                        FN_SRAV: write_gpr(rd, $unsigned($signed(vt) >>> vs[4:0]));
                        FN_JR, FN_JALR: begin
                            if (vs[1:0] != 2'd0) begin
                                r.status = ST_JADDR;
                            end else begin
                                if (fn == FN_JALR)
                                    write_gpr(rd, npc_q);
                                npc_q = vs;
                            end
                        end
                        FN_SYSC: begin
                            cp0[CP_EPC] = iaddr;
                            sr = cp0[CP_SR];
                            cp0[CP_SR] = (sr & ~32'h3f) | ((sr << 2) & 32'h3f);
                            cp0[CP_CAUSE] = (cp0[CP_CAUSE] & ~32'h7c) | (32'(EXC_SYS) << 2);
                            pc_q  = cp0[CP_SR][22] ? VEC_BEV1 : VEC_BEV0;
                            npc_q = pc_q + 4;
                        end
                        FN_MFHI: write_gpr(rd, hi_q);
                        FN_MTHI: hi_q = vs;
                        FN_MFLO: write_gpr(rd, lo_q);
                        FN_MTLO: lo_q = vs;
                        FN_MULT: begin
                            prod = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
                            {hi_q, lo_q} = prod;
                        end
                        FN_MULTU: begin
                            prod = {32'd0, vs} * {32'd0, vt};
                            {hi_q, lo_q} = prod;
                        end
                        FN_DIV: signed_divide(vs, vt);
                        FN_DIVU: begin
                            if (vt == 0) begin
                                lo_q = ALL_ONES;
                                hi_q = vs;
                            end else begin
                                lo_q = vs / vt;
                                hi_q = vs % vt;
                            end
                        end
                        FN_ADD, FN_ADDU: write_gpr(rd, vs + vt);
                        FN_SUB, FN_SUBU: write_gpr(rd, vs - vt);
                        FN_AND:  write_gpr(rd, vs & vt);
                        FN_OR:   write_gpr(rd, vs | vt);
                        FN_XOR:  write_gpr(rd, vs ^ vt);
                        FN_NOR:  write_gpr(rd, ~(vs | vt));
                        FN_SLT:  write_gpr(rd, {31'd0, $signed(vs) < $signed(vt)});
                        FN_SLTU: write_gpr(rd, {31'd0, vs < vt});
                        default: r.status = ST_UNIMP;
                    endcase
                end
                OP_REGIMM: begin
                    if (rt[3:1] == 3'd0) begin
                        neg  = vs[31];
                        take = rt[0] ? !neg : neg;
                        if (rt[4])
                            write_gpr(5'd31, npc_q);
                        if (take)
                            npc_q = btgt;
                    end else begin
                        r.status = ST_UNIMP;
                    end
                end
                OP_J, OP_JAL: begin
                    if (opc == OP_JAL)
                        write_gpr(5'd31, npc_q);
                    npc_q = (pc_q & SEG_MASK) | {4'd0, w[25:0] & TARGET_MASK, 2'd0};
                end
                OP_BEQ:  if (vs == vt) npc_q = btgt;
                OP_BNE:  if (vs != vt) npc_q = btgt;
                OP_BLEZ: if (vs == 0 || vs[31]) npc_q = btgt;
                OP_BGTZ: if (vs != 0 && !vs[31]) npc_q = btgt;
                OP_ADDI, OP_ADDIU: write_gpr(rt, vs + simm);
                OP_SLTI:  write_gpr(rt, {31'd0, $signed(vs) < $signed(simm)});
                OP_SLTIU: write_gpr(rt, {31'd0, vs < simm});
                OP_ANDI:  write_gpr(rt, vs & imm);
                OP_ORI:   write_gpr(rt, vs | imm);
                OP_XORI:  write_gpr(rt, vs ^ imm);
                OP_LUI:   write_gpr(rt, imm << 16);
                OP_COP0: begin
                    if (w[25]) begin
                        if (fn == FN_RFE)
                            cp0[CP_SR][3:0] = cp0[CP_SR][5:2];
                        else
                            r.status = ST_UNIMP;
                    end else if (rs == RS_MFC0) begin
                        write_gpr(rt, rd[4] ? 32'd0 : cp0[rd[3:0]]);
                    end else if (rs == RS_MTC0) begin
                        if (!rd[4])
                            cp0[rd[3:0]] = vt;
                    end else begin
                        r.status = ST_UNIMP;
                    end
                end
                OP_SB: begin
                    r.bus_request = REQ_WRITE;
                    r.bus_write_data = (vt & 32'hff) << (8 * a);
                    r.byte_enables = 4'd1 << a;
                end
                OP_SH: begin
                    r.bus_request = REQ_WRITE;
                    r.bus_write_data = (vt & 32'hffff) << (8 * (a & 2'd2));
                    r.byte_enables = 4'd3 << (a & 2'd2);
                end
                OP_SWL: begin
                    r.bus_request = REQ_WRITE;
                    r.bus_write_data = vt >> (24 - 8 * a);
                    r.byte_enables = 4'((5'd2 << a) - 5'd1);
                end
                OP_SW: begin
                    r.bus_request = REQ_WRITE;
                    r.bus_write_data = vt;
                    r.byte_enables = 4'hf;
                end
                OP_SWR: begin
                    r.bus_request = REQ_WRITE;
                    r.bus_write_data = vt << (8 * a);
                    r.byte_enables = 4'hf << a;
                end
                default: begin
                    if (opc >= OP_LB && opc <= OP_LWR) begin
                        r.bus_request = REQ_READ;
                        ld_pend = 1'b1;
                        ld_kind = opc[2:0];
                        ld_reg  = rt;
                        ld_low  = a;
                    end else begin
                        r.status = ST_UNIMP;
                    end
                end
            endcase
            if (r.bus_request != REQ_NONE)
                r.bus_address = {ea[31:2], 2'b00};
        end
        r.fetch_address = pc_q;
    endtask

    task automatic load_boot_vector(input logic [31:0] v);
        pc_q  = v;
        npc_q = v + 4;
    endtask

    always @(posedge aclk) begin
        result_t exp_r;
        result_t got;
        if (!aresetn) begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (cp0[i]) cp0[i] = '0;
            hi_q = '0;
            lo_q = '0;
            ld_pend = 1'b0;
            load_boot_vector(RESET_VECTOR);
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_START)
                load_boot_vector(pwdata);
            if (m_tvalid && m_tready) begin
                got.fetch_address  = m_tdata[31:0];
                got.bus_request    = m_tdata[33:32];
                got.bus_address    = m_tdata[65:34];
                got.bus_write_data = m_tdata[97:66];
                got.byte_enables   = m_tdata[101:98];
                got.status         = m_tdata[103:102];
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.fetch_address !== exp_r.fetch_address) begin
                        $error("fetch_address: expected %h, got %h",
                               exp_r.fetch_address, got.fetch_address);
                        mismatch_count++;
                    end
                    if (got.bus_request !== exp_r.bus_request) begin
                        $error("bus_request: expected %h, got %h",
                               exp_r.bus_request, got.bus_request);
                        mismatch_count++;
                    end
                    if (got.bus_address !== exp_r.bus_address) begin
                        $error("bus_address: expected %h, got %h",
                               exp_r.bus_address, got.bus_address);
                        mismatch_count++;
                    end
                    if (got.bus_write_data !== exp_r.bus_write_data) begin
                        $error("bus_write_data: expected %h, got %h",
                               exp_r.bus_write_data, got.bus_write_data);
                        mismatch_count++;
                    end
                    if (got.byte_enables !== exp_r.byte_enables) begin
                        $error("byte_enables: expected %h, got %h",
                               exp_r.byte_enables, got.byte_enables);
                        mismatch_count++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status: expected %h, got %h", exp_r.status, got.status);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                execute_beat(s_tuser, s_tdata[31:0], s_tdata[63:32], exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

@@ test/tb_mips_r3000_integer_core_unit.sv @@
// Top of the R3000A core testbench: clock, reset, APB writes, instruction and
// load-data beats, random back-pressure and the verdict.
// Depends on mrc_pkg, mips_r3000_integer_core_unit and mrc_result_checker.
module tb_mips_r3000_integer_core_unit;
    import mrc_pkg::*;

    // opcodes and codes the package does not name
    localparam logic [5:0] OP_LH   = 6'h21;
    localparam logic [5:0] OP_LWL  = 6'h22;
    localparam logic [5:0] OP_LW   = 6'h23;
    localparam logic [5:0] OP_LBU  = 6'h24;
    localparam logic [5:0] OP_LHU  = 6'h25;
    localparam logic [5:0] OP_COP1 = 6'h11;
    localparam logic [5:0] FN_BRK  = 6'h0d;
    localparam logic [4:0] RT_BLTZ   = 5'h00;
    localparam logic [4:0] RT_BGEZ   = 5'h01;
    localparam logic [4:0] RT_BLTZAL = 5'h10;
    localparam logic [4:0] RT_BGEZAL = 5'h11;
    localparam logic [4:0] RT_BAD    = 5'h05;
    localparam logic [1:0] ADDR_START = 2'd0;
    localparam logic       BEAT_EXEC = 1'b0;
    localparam logic       BEAT_LOAD = 1'b1;
    localparam int         WATCHDOG_LIMIT = 2000;  // longer than the HOLD_CYCLES hold-off
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 50;    // longer than a divide

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;   // instruction_word[31:0], load_word[63:32]
    logic         s_tuser = 1'b0; // operation
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;        // fetch_address[31:0], bus_request[33:32],
                                  // bus_address[65:34], bus_write_data[97:66],
                                  // byte_enables[101:98], status[103:102]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int mismatch_count;
    int results_due;
    bit no_gaps;        // phases without idling on either side
    bit hold_request;   // receiver holds off for a long stretch
    int idle_cycles;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mips_r3000_integer_core_unit dut (.*);

    mrc_result_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatch_count, .results_due
    );

    // watchdog: a stretch with no beat on either channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mips_r3000_integer_core_unit regression: fail");
            $finish;
        end
    end

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready = 1'b0;
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            repeat (stall) @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one beat on the input channel; returns at the falling edge after acceptance
    task automatic send_beat(input logic op, input logic [31:0] w, input logic [31:0] ldw);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {ldw, w};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic exec(input logic [31:0] w);
        send_beat(BEAT_EXEC, w, $urandom);
    endtask

    task automatic wait_drained;
        s_tvalid = 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] v);
        psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = v;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // registers are mostly drawn from a small set so results feed later beats
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_insn();
        logic [5:0] alu_fn [19] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
            FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
            FN_SLTU, FN_MFHI, FN_MFLO, FN_BRK};
        logic [5:0] md_fn [6] = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_MTHI, FN_MTLO};
        logic [5:0] imm_op [8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
            OP_XORI, OP_LUI};
        logic [5:0] st_op [5] = '{OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR};
        logic [5:0] br_op [6] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
        logic [4:0] ri_rt [5] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL, RT_BAD};
        logic [4:0] cp_idx;
        cp_idx = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(12, 14));
        case ($urandom_range(0, 19))
            0, 1, 2, 3:
                return rtype(alu_fn[$urandom_range(0, 18)], pick_reg(), pick_reg(),
                             pick_reg(), 5'($urandom));
            4, 5, 6, 7:
                return itype(imm_op[$urandom_range(0, 7)], pick_reg(), pick_reg(), pick_imm());
            8, 9:
                return rtype(md_fn[$urandom_range(0, 5)], pick_reg(), pick_reg(), 5'd0, 5'd0);
            10, 11, 12:
                return itype(6'($urandom_range(OP_LB, OP_LWR)), pick_reg(), pick_reg(),
                             pick_imm());
            13, 14:
                return itype(st_op[$urandom_range(0, 4)], pick_reg(), pick_reg(), pick_imm());
            15:
                return {br_op[$urandom_range(0, 5)], pick_reg(), pick_reg(), pick_imm()};
            16: begin
                case ($urandom_range(0, 2))
                    0: return itype(OP_REGIMM, pick_reg(), ri_rt[$urandom_range(0, 4)],
                                    pick_imm());
                    1: return rtype(FN_JR, pick_reg(), 5'd0, 5'd0, 5'd0);
                    default: return rtype(FN_JALR, pick_reg(), 5'd0, pick_reg(), 5'd0);
                endcase
            end
            17: begin
                case ($urandom_range(0, 4))
                    0: return {OP_COP0, RS_MFC0, pick_reg(), cp_idx, 11'd0};
                    1: return {OP_COP0, RS_MTC0, pick_reg(), cp_idx, 11'd0};
                    2: return {OP_COP0, 1'b1, 19'd0, FN_RFE};
                    3: return rtype(FN_SYSC, 5'd0, 5'd0, 5'd0, 5'd0);
                    default: return {OP_COP0, 1'b1, 19'($urandom), 6'($urandom)};
                endcase
            end
            default:
                return $urandom;  // noise
        endcase
    endfunction

    // a random beat: mostly well-formed, loads followed by their data
    task automatic random_beat();
        logic [31:0] w;
        if ($urandom_range(0, 19) == 0) begin
            send_beat(BEAT_LOAD, $urandom, $urandom);  // stray load data
        end else begin
            w = random_insn();
            exec(w);
            if (w[31:26] >= OP_LB && w[31:26] <= OP_LWR && $urandom_range(0, 9) != 0)
                send_beat(BEAT_LOAD, $urandom, $urandom);
        end
    endtask

    initial begin
        logic [31:0] boot_values [4];
        boot_values = '{32'hffff_ffff, $urandom, RESET_VECTOR, 32'h0000_0000};
        no_gaps = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: first run from the reset vector, then from address zero
        exec(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));          // r1 = 0x80000000
        exec(itype(OP_ADDIU, 5'd0, 5'd2, 16'hffff));        // r2 = -1
        exec(rtype(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));        // signed overflow divide
        exec(rtype(FN_MFLO, 5'd0, 5'd0, 5'd3, 5'd0));
        exec(rtype(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0));       // divide by zero
        exec(rtype(FN_MFHI, 5'd0, 5'd0, 5'd3, 5'd0));
        exec(rtype(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
        exec(rtype(FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0));        // wraps, no trap
        exec(itype(OP_LUI, 5'd0, 5'd5, 16'h0040));          // BEV set
        exec(itype(OP_ORI, 5'd5, 5'd5, 16'h003f));
        exec({OP_COP0, RS_MTC0, 5'd5, 5'(CP_SR), 11'd0});
        exec(rtype(FN_SYSC, 5'd0, 5'd0, 5'd0, 5'd0));
        exec({OP_COP0, 1'b1, 19'd0, FN_RFE});
        exec({OP_COP0, RS_MFC0, 5'd6, 5'(CP_EPC), 11'd0});
        exec({OP_COP0, RS_MTC0, 5'd5, 5'd20, 11'd0});       // index above 15: ignored
        exec({OP_COP0, RS_MFC0, 5'd6, 5'd20, 11'd0});
        exec(rtype(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));         // misaligned jump
        exec(rtype(FN_BRK, 5'd0, 5'd0, 5'd0, 5'd0));        // unimplemented
        exec({OP_COP1, 26'd0});
        exec(itype(OP_LWL, 5'd2, 5'd7, 16'h0004));          // low bits 3
        send_beat(BEAT_LOAD, 32'd0, 32'hffff_ffff);
        send_beat(BEAT_LOAD, 32'hffff_ffff, 32'h1234_5678);  // nothing pending
        exec(itype(OP_LB, 5'd0, 5'd0, 16'h0003));            // load into r0
        send_beat(BEAT_LOAD, 32'd0, 32'h0000_0080);
        exec(itype(OP_LW, 5'd0, 5'd8, 16'h0000));            // abandoned by next beat
        exec(itype(OP_SWR, 5'd2, 5'd1, 16'h0004));
        wait_drained();

        // random phases, each after a fresh boot vector
        for (int ph = 0; ph < 5; ph++) begin
            apb_write(ADDR_START, ph == 0 ? 32'h0 : boot_values[ph - 1]);
            no_gaps = (ph == 2);
            if (ph == 3)
                hold_request = 1'b1;  // sender keeps offering meanwhile
            for (int i = 0; i < 90; i++)
                random_beat();
            wait_drained();           // sender pause until every result is back
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("mips_r3000_integer_core_unit regression: pass");
        else
            $display("mips_r3000_integer_core_unit regression: fail");
        $finish;
    end
endmodule
